// ----- rtl/osf_pkg.sv -----
package osf_pkg;

   // Default size of the value universe; values run from 0 to UNIVERSE_DEF-1.
   localparam int UNIVERSE_DEF = 1024;

   // Fixed field widths of the request and response channels.
   localparam int OPERAND_W = 11;
   localparam int ANSWER_W  = 11;

   typedef logic [OPERAND_W-1:0] operand_type;
   typedef logic [ANSWER_W-1:0]  answer_type;

   // Command codes carried on the request channel.
   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_KTH    = 2'd2,
      CMD_COUNT  = 2'd3
   } cmd_type;

   // Operation select of the shared adder.
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   // Port enables of the count store.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ram_ctl_type;

endpackage

// ----- rtl/osf_alu.sv -----
module osf_alu #(
   parameter int WIDTH = $clog2(osf_pkg::UNIVERSE_DEF + 1)
) (
   input  osf_pkg::alu_op_type op,
   input  logic [WIDTH-1:0]    a,
   input  logic [WIDTH-1:0]    b,
   output logic [WIDTH-1:0]    result,
   output logic                carry_out
);

   logic [WIDTH:0] full;

   // One adder shared by prefix sums, node updates and rank compares.
   // On a subtract the top bit is the borrow.
   always_comb begin
      case (op)
         osf_pkg::ALU_ADD: full = {1'b0, a} + {1'b0, b};
         osf_pkg::ALU_SUB: full = {1'b0, a} - {1'b0, b};
         default:          full = '0;
      endcase
   end

   assign result    = full[WIDTH-1:0];
   assign carry_out = full[WIDTH];

endmodule

// ----- rtl/osf_ram.sv -----
module osf_ram #(
   parameter int DEPTH  = osf_pkg::UNIVERSE_DEF,
   parameter int DATA_W = $clog2(osf_pkg::UNIVERSE_DEF + 1)
) (
   input  logic                       clock,
   input  osf_pkg::ram_ctl_type       ctl,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [DATA_W-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [DATA_W-1:0]          rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // One write port and one read port with registered read data.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/osf_ctrl.sv -----
module osf_ctrl #(
   parameter int UNIVERSE = osf_pkg::UNIVERSE_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  osf_pkg::cmd_type                     req_command,
   input  osf_pkg::operand_type                 req_operand,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output osf_pkg::answer_type                  rsp_answer,
   output logic                                 rsp_invalid,
   output osf_pkg::ram_ctl_type                 ram_ctl,
   output logic [$clog2(UNIVERSE)-1:0]          ram_wr_addr,
   output logic [$clog2(UNIVERSE+1)-1:0]        ram_wr_data,
   output logic [$clog2(UNIVERSE)-1:0]          ram_rd_addr,
   input  logic [$clog2(UNIVERSE+1)-1:0]        ram_rd_data,
   output osf_pkg::alu_op_type                  alu_op,
   output logic [$clog2(UNIVERSE+1)-1:0]        alu_a,
   output logic [$clog2(UNIVERSE+1)-1:0]        alu_b,
   input  logic [$clog2(UNIVERSE+1)-1:0]        alu_result,
   input  logic                                 alu_carry
);

   localparam int AW = $clog2(UNIVERSE);
   localparam int CW = $clog2(UNIVERSE + 1);
   // Tree positions need one more bit: an update walk steps past UNIVERSE.
   localparam int PW = CW + 1;
   localparam int WW = (PW > osf_pkg::OPERAND_W + 1) ? PW : osf_pkg::OPERAND_W + 1;
   localparam int TOP_STEP = 2 ** (CW - 1);

   typedef logic [AW-1:0] addr_type;
   typedef logic [CW-1:0] cnt_type;
   typedef logic [PW-1:0] pos_type;
   typedef logic [WW-1:0] wide_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SUM,
      ST_UPD,
      ST_KREAD,
      ST_KCMP,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      PH_HI,
      PH_LO,
      PH_TOTAL,
      PH_COUNT
   } phase_type;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   osf_pkg::cmd_type     cmd_ff, cmd_in;
   osf_pkg::operand_type opd_ff, opd_in;
   pos_type              p_ff, p_in;
   logic                 pend_ff, pend_in;
   cnt_type              acc_ff, acc_in;
   cnt_type              hi_ff, hi_in;
   addr_type             wa_ff, wa_in;
   pos_type              step_ff, step_in;
   pos_type              pos_ff, pos_in;
   cnt_type              rem_ff, rem_in;
   addr_type             clr_ff, clr_in;
   osf_pkg::answer_type  res_ans_ff, res_ans_in;
   logic                 res_inv_ff, res_inv_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   osf_pkg::answer_type  rsp_answer_ff, rsp_answer_in;
   logic                 rsp_invalid_ff, rsp_invalid_in;

   wide_type opd_wide;
   wide_type req_wide;
   wide_type universe_wide;
   pos_type  lowbit;
   logic     p_nz;
   logic     p_in_range;
   pos_type  nxt;
   logic     nxt_ok;
   logic     present;
   logic     need_update;
   logic     kth_take;

   // Position arithmetic of the tree walks.
   assign opd_wide      = wide_type'(opd_ff);
   assign req_wide      = wide_type'(req_operand);
   assign universe_wide = wide_type'(UNIVERSE);
   assign lowbit        = p_ff & (~p_ff + pos_type'(1));
   assign p_nz          = (p_ff != '0);
   assign p_in_range    = p_nz && (p_ff <= pos_type'(UNIVERSE));
   assign nxt           = pos_ff + step_ff;
   assign nxt_ok        = (nxt <= pos_type'(UNIVERSE));

   // Membership follows from the two prefix sums around the value.
   assign present     = (hi_ff != acc_ff);
   assign need_update = (cmd_ff == osf_pkg::CMD_INSERT) ? !present : present;

   // The node count is below the remaining rank when the subtract neither
   // borrows nor lands on zero.
   assign kth_take = !alu_carry && (alu_result != '0);

   // Shared adder operands for each walk.
   always_comb begin
      alu_op = osf_pkg::ALU_ADD;
      alu_a  = acc_ff;
      alu_b  = ram_rd_data;
      case (state_ff)
         ST_UPD: begin
            alu_op = (cmd_ff == osf_pkg::CMD_INSERT) ? osf_pkg::ALU_ADD : osf_pkg::ALU_SUB;
            alu_a  = ram_rd_data;
            alu_b  = cnt_type'(1);
         end
         ST_KCMP: begin
            alu_op = osf_pkg::ALU_SUB;
            alu_a  = rem_ff;
            alu_b  = ram_rd_data;
         end
         default: begin
            alu_op = osf_pkg::ALU_ADD;
            alu_a  = acc_ff;
            alu_b  = ram_rd_data;
         end
      endcase
   end

   // Sequencer: next state, walk registers and store accesses.
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      cmd_in         = cmd_ff;
      opd_in         = opd_ff;
      p_in           = p_ff;
      pend_in        = 1'b0;
      acc_in         = acc_ff;
      hi_in          = hi_ff;
      wa_in          = wa_ff;
      step_in        = step_ff;
      pos_in         = pos_ff;
      rem_in         = rem_ff;
      clr_in         = clr_ff;
      res_ans_in     = res_ans_ff;
      res_inv_in     = res_inv_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_answer_in  = rsp_answer_ff;
      rsp_invalid_in = rsp_invalid_ff;
      ram_ctl        = '0;
      ram_rd_addr    = addr_type'(p_ff - pos_type'(1));
      ram_wr_addr    = wa_ff;
      ram_wr_data    = alu_result;

      // The output register empties on a transfer.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_ctl.wr_en = 1'b1;
            ram_wr_addr   = clr_ff;
            ram_wr_data   = '0;
            clr_in        = clr_ff + addr_type'(1);
            if (clr_ff == addr_type'(UNIVERSE - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_command;
               opd_in = req_operand;
               acc_in = '0;
               case (req_command)
                  osf_pkg::CMD_INSERT, osf_pkg::CMD_DELETE: begin
                     // Out-of-universe values are dropped here.
                     if (req_wide < universe_wide) begin
                        p_in     = pos_type'(req_wide + wide_type'(1));
                        phase_in = PH_HI;
                        state_in = ST_SUM;
                     end
                  end
                  osf_pkg::CMD_KTH: begin
                     p_in     = pos_type'(UNIVERSE);
                     phase_in = PH_TOTAL;
                     state_in = ST_SUM;
                  end
                  osf_pkg::CMD_COUNT: begin
                     p_in     = (req_wide < universe_wide) ? pos_type'(req_wide)
                                                           : pos_type'(UNIVERSE);
                     phase_in = PH_COUNT;
                     state_in = ST_SUM;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SUM: begin
            // Reads are issued back to back; each one is added in the cycle after it is issued.
            if (pend_ff) begin
               acc_in = alu_result;
            end
            if (p_nz) begin
               ram_ctl.rd_en = 1'b1;
               p_in          = p_ff - lowbit;
               pend_in       = 1'b1;
            end else if (!pend_ff) begin
               case (phase_ff)
                  PH_HI: begin
                     hi_in    = acc_ff;
                     acc_in   = '0;
                     p_in     = pos_type'(opd_wide);
                     phase_in = PH_LO;
                  end
                  PH_LO: begin
                     if (need_update) begin
                        p_in     = pos_type'(opd_wide + wide_type'(1));
                        state_in = ST_UPD;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
                  PH_TOTAL: begin
                     if (opd_wide == '0 || opd_wide > wide_type'(acc_ff)) begin
                        res_ans_in = '0;
                        res_inv_in = 1'b1;
                        state_in   = ST_RESP;
                     end else begin
                        step_in  = pos_type'(TOP_STEP);
                        pos_in   = '0;
                        rem_in   = cnt_type'(opd_ff);
                        state_in = ST_KREAD;
                     end
                  end
                  PH_COUNT: begin
                     res_ans_in = osf_pkg::answer_type'(acc_ff);
                     res_inv_in = 1'b0;
                     state_in   = ST_RESP;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_UPD: begin
            // Write back the previous node while reading the next one.
            if (pend_ff) begin
               ram_ctl.wr_en = 1'b1;
            end
            if (p_in_range) begin
               ram_ctl.rd_en = 1'b1;
               wa_in         = addr_type'(p_ff - pos_type'(1));
               p_in          = p_ff + lowbit;
               pend_in       = 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_IDLE;
            end
         end

         ST_KREAD: begin
            if (step_ff == '0) begin
               res_ans_in = osf_pkg::answer_type'(pos_ff);
               res_inv_in = 1'b0;
               state_in   = ST_RESP;
            end else if (nxt_ok) begin
               ram_ctl.rd_en = 1'b1;
               ram_rd_addr   = addr_type'(nxt - pos_type'(1));
               state_in      = ST_KCMP;
            end else begin
               step_in = step_ff >> 1;
            end
         end

         ST_KCMP: begin
            if (kth_take) begin
               pos_in = nxt;
               rem_in = alu_result;
            end
            step_in  = step_ff >> 1;
            state_in = ST_KREAD;
         end

         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_answer_in  = res_ans_ff;
               rsp_invalid_in = res_inv_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff       <= phase_in;
      cmd_ff         <= cmd_in;
      opd_ff         <= opd_in;
      p_ff           <= p_in;
      acc_ff         <= acc_in;
      hi_ff          <= hi_in;
      wa_ff          <= wa_in;
      step_ff        <= step_in;
      pos_ff         <= pos_in;
      rem_ff         <= rem_in;
      res_ans_ff     <= res_ans_in;
      res_inv_ff     <= res_inv_in;
      rsp_answer_ff  <= rsp_answer_in;
      rsp_invalid_ff <= rsp_invalid_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_answer  = rsp_answer_ff;
   assign rsp_invalid = rsp_invalid_ff;

`ifndef ASSERT_OFF
   a_rw_distinct: assert property (@(posedge clock) disable iff (reset)
      (ram_ctl.rd_en && ram_ctl.wr_en) |-> (ram_rd_addr != ram_wr_addr))
      else $error("Read and write of the same tree node in one cycle.");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (acc_ff <= cnt_type'(UNIVERSE)))
      else $error("Prefix sum exceeds the universe size.");

   a_kth_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_KCMP) |-> (step_ff != '0 && nxt_ok))
      else $error("Rank compare without a valid tree node.");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_invalid_ff) |-> (rsp_answer_ff == '0))
      else $error("Invalid result carries a nonzero answer.");

   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && !(rsp_valid_ff && rsp_stall))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("Finished result was not loaded into the output register.");
`endif

endmodule

// ----- rtl/order_statistic_set_fenwick.sv -----
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_command, req_operand
// rsp       out        rsp_valid/rsp_stall  rsp_answer, rsp_invalid
//
// One request at a time: req_stall is high from the accepting edge until idle.
// A prefix-sum walk reads one tree node per step, an update walk reads each node
// while writing back the one before, and the k-th descent reads then compares per level.
// Insert and delete take two prefix-sum walks (plus an update walk on a change),
// a count one prefix-sum walk, and a k-th query a total walk and then the descent.
// Reset clears all UNIVERSE nodes first; a stalled response delays only the next.
module order_statistic_set_fenwick #(
   parameter int UNIVERSE = osf_pkg::UNIVERSE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  osf_pkg::cmd_type     req_command,
   input  osf_pkg::operand_type req_operand,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output osf_pkg::answer_type  rsp_answer,
   output logic                 rsp_invalid
);

   localparam int AW = $clog2(UNIVERSE);
   localparam int CW = $clog2(UNIVERSE + 1);

   osf_pkg::ram_ctl_type ram_ctl;
   logic [AW-1:0]        ram_wr_addr;
   logic [CW-1:0]        ram_wr_data;
   logic [AW-1:0]        ram_rd_addr;
   logic [CW-1:0]        ram_rd_data;
   osf_pkg::alu_op_type  alu_op;
   logic [CW-1:0]        alu_a;
   logic [CW-1:0]        alu_b;
   logic [CW-1:0]        alu_result;
   logic                 alu_carry;

   // Sequencer with the walk registers and the output register.
   osf_ctrl #(
      .UNIVERSE (UNIVERSE)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_operand (req_operand),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_answer  (rsp_answer),
      .rsp_invalid (rsp_invalid),
      .ram_ctl     (ram_ctl),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .alu_op      (alu_op),
      .alu_a       (alu_a),
      .alu_b       (alu_b),
      .alu_result  (alu_result),
      .alu_carry   (alu_carry)
   );

   // Fenwick count store.
   osf_ram #(
      .DEPTH  (UNIVERSE),
      .DATA_W (CW)
   ) u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Shared adder.
   osf_alu #(
      .WIDTH (CW)
   ) u_alu (
      .op        (alu_op),
      .a         (alu_a),
      .b         (alu_b),
      .result    (alu_result),
      .carry_out (alu_carry)
   );

endmodule
